### rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

    // hue sector bases, in units of chroma
    localparam int unsigned GREEN_BASE   = 2;
    localparam int unsigned BLUE_BASE    = 4;
    localparam int unsigned SECTOR_COUNT = 6;

    typedef struct packed {
        logic sat_zero;
        logic sat_full;
        logic hue_zero;
    } flags_t;

endpackage

### rtl/rgbhsv_front.sv
module rgbhsv_front #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CHANNEL_BITS-1:0]   in_red,
    input  logic [CHANNEL_BITS-1:0]   in_green,
    input  logic [CHANNEL_BITS-1:0]   in_blue,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CHANNEL_BITS-1:0]   out_sat_rem,
    output logic [CHANNEL_BITS-1:0]   out_sat_div,
    output logic [CHANNEL_BITS+2:0]   out_hue_rem,
    output logic [CHANNEL_BITS+2:0]   out_hue_div,
    output logic [CHANNEL_BITS-1:0]   out_value,
    output rgbhsv_pkg::flags_t        out_flags
);

    localparam int HW = CHANNEL_BITS + 3;

    logic                    valid_reg;
    logic [CHANNEL_BITS-1:0] sat_rem_reg;
    logic [CHANNEL_BITS-1:0] sat_div_reg;
    logic [HW-1:0]           hue_rem_reg;
    logic [HW-1:0]           hue_div_reg;
    rgbhsv_pkg::flags_t      flags_reg;

    logic                    red_max;
    logic                    green_max;
    logic [CHANNEL_BITS-1:0] max_val;
    logic [CHANNEL_BITS-1:0] min_val;
    logic [CHANNEL_BITS-1:0] chroma;
    logic [HW-1:0]           c_ext;
    logic [HW-1:0]           r_ext;
    logic [HW-1:0]           g_ext;
    logic [HW-1:0]           b_ext;
    logic [HW-1:0]           hue_rem_next;
    logic [HW-1:0]           hue_div_next;
    rgbhsv_pkg::flags_t      flags_next;

    // ties go to red, then green
    assign red_max   = (in_red >= in_green) && (in_red >= in_blue);
    assign green_max = !red_max && (in_green >= in_blue);

    always_comb begin
        if (red_max) begin
            max_val = in_red;
        end else if (green_max) begin
            max_val = in_green;
        end else begin
            max_val = in_blue;
        end
        min_val = in_red;
        if (in_green < min_val) begin
            min_val = in_green;
        end
        if (in_blue < min_val) begin
            min_val = in_blue;
        end
    end

    assign chroma = max_val - min_val;
    assign c_ext  = HW'(chroma);
    assign r_ext  = HW'(in_red);
    assign g_ext  = HW'(in_green);
    assign b_ext  = HW'(in_blue);

    assign hue_div_next = c_ext * HW'(rgbhsv_pkg::SECTOR_COUNT);

    always_comb begin
        if (red_max) begin
            if (in_green >= in_blue) begin
                hue_rem_next = g_ext - b_ext;
            end else begin
                hue_rem_next = hue_div_next - (b_ext - g_ext);
            end
        end else if (green_max) begin
            hue_rem_next = c_ext * HW'(rgbhsv_pkg::GREEN_BASE) + b_ext - r_ext;
        end else begin
            hue_rem_next = c_ext * HW'(rgbhsv_pkg::BLUE_BASE) + r_ext - g_ext;
        end
    end

    always_comb begin
        flags_next.sat_zero = (max_val == '0);
        flags_next.sat_full = (chroma == max_val) && (max_val != '0);
        flags_next.hue_zero = (chroma == '0);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sat_rem_reg <= chroma;
            sat_div_reg <= max_val;
            hue_rem_reg <= hue_rem_next;
            hue_div_reg <= hue_div_next;
            flags_reg   <= flags_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_sat_rem = sat_rem_reg;
    assign out_sat_div = sat_div_reg;
    assign out_hue_rem = hue_rem_reg;
    assign out_hue_div = hue_div_reg;
    assign out_value   = sat_div_reg;
    assign out_flags   = flags_reg;

endmodule

### rtl/rgbhsv_cell.sv
module rgbhsv_cell #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CHANNEL_BITS-1:0]    in_sat_rem,
    input  logic [CHANNEL_BITS-1:0]    in_sat_div,
    input  logic [CHANNEL_BITS+2:0]    in_hue_rem,
    input  logic [CHANNEL_BITS+2:0]    in_hue_div,
    input  logic [FRACTION_BITS-1:0]   in_sat_q,
    input  logic [FRACTION_BITS-1:0]   in_hue_q,
    input  logic [CHANNEL_BITS-1:0]    in_value,
    input  rgbhsv_pkg::flags_t         in_flags,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [CHANNEL_BITS-1:0]    out_sat_rem,
    output logic [CHANNEL_BITS-1:0]    out_sat_div,
    output logic [CHANNEL_BITS+2:0]    out_hue_rem,
    output logic [CHANNEL_BITS+2:0]    out_hue_div,
    output logic [FRACTION_BITS-1:0]   out_sat_q,
    output logic [FRACTION_BITS-1:0]   out_hue_q,
    output logic [CHANNEL_BITS-1:0]    out_value,
    output rgbhsv_pkg::flags_t         out_flags
);

    localparam int HW = CHANNEL_BITS + 3;

    logic                     valid_reg;
    logic [CHANNEL_BITS-1:0]  sat_rem_reg;
    logic [CHANNEL_BITS-1:0]  sat_div_reg;
    logic [HW-1:0]            hue_rem_reg;
    logic [HW-1:0]            hue_div_reg;
    logic [FRACTION_BITS-1:0] sat_q_reg;
    logic [FRACTION_BITS-1:0] hue_q_reg;
    logic [CHANNEL_BITS-1:0]  value_reg;
    rgbhsv_pkg::flags_t       flags_reg;

    logic [CHANNEL_BITS:0]    sat_shift;
    logic [CHANNEL_BITS:0]    sat_diff;
    logic                     sat_bit;
    logic [CHANNEL_BITS-1:0]  sat_rem_next;
    logic [HW:0]              hue_shift;
    logic [HW:0]              hue_diff;
    logic                     hue_bit;
    logic [HW-1:0]            hue_rem_next;

    // one restoring step per quotient bit
    assign sat_shift    = {in_sat_rem, 1'b0};
    assign sat_diff     = sat_shift - {1'b0, in_sat_div};
    assign sat_bit      = (sat_shift >= {1'b0, in_sat_div});
    assign sat_rem_next = sat_bit ? sat_diff[CHANNEL_BITS-1:0] : sat_shift[CHANNEL_BITS-1:0];

    assign hue_shift    = {in_hue_rem, 1'b0};
    assign hue_diff     = hue_shift - {1'b0, in_hue_div};
    assign hue_bit      = (hue_shift >= {1'b0, in_hue_div});
    assign hue_rem_next = hue_bit ? hue_diff[HW-1:0] : hue_shift[HW-1:0];

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sat_rem_reg <= sat_rem_next;
            sat_div_reg <= in_sat_div;
            hue_rem_reg <= hue_rem_next;
            hue_div_reg <= in_hue_div;
            sat_q_reg   <= {in_sat_q[FRACTION_BITS-2:0], sat_bit};
            hue_q_reg   <= {in_hue_q[FRACTION_BITS-2:0], hue_bit};
            value_reg   <= in_value;
            flags_reg   <= in_flags;
        end
    end

    assign out_valid   = valid_reg;
    assign out_sat_rem = sat_rem_reg;
    assign out_sat_div = sat_div_reg;
    assign out_hue_rem = hue_rem_reg;
    assign out_hue_div = hue_div_reg;
    assign out_sat_q   = sat_q_reg;
    assign out_hue_q   = hue_q_reg;
    assign out_value   = value_reg;
    assign out_flags   = flags_reg;

endmodule

### rtl/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter. Takes one pixel per clock and gives value (largest channel),
// saturation (chroma over value, unsigned Q0.FRACTION_BITS, full saturation clamped
// to all ones) and hue (fraction of a turn, Q0.FRACTION_BITS, truncated). A front
// register stage finds max, min and hue sector; then a chain of FRACTION_BITS divider
// cells each settle one bit of both quotients. Throughput is one pixel per clock;
// each cell stalls only when it is full and its neighbor does not take its request,
// so bubbles in the chain are absorbed.
module rgb_to_hsv_converter_unit #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // red, green, blue
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]          s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // hue, saturation, value
    output logic [((2*FRACTION_BITS+CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int HW     = CHANNEL_BITS + 3;
    localparam int OUT_W  = ((2*FRACTION_BITS+CHANNEL_BITS+7)/8)*8;
    localparam int PACK_W = 2*FRACTION_BITS + CHANNEL_BITS;

    logic                     valid [FRACTION_BITS+1];
    logic                     ready [FRACTION_BITS+1];
    logic [CHANNEL_BITS-1:0]  sat_rem [FRACTION_BITS+1];
    logic [CHANNEL_BITS-1:0]  sat_div [FRACTION_BITS+1];
    logic [HW-1:0]            hue_rem [FRACTION_BITS+1];
    logic [HW-1:0]            hue_div [FRACTION_BITS+1];
    logic [FRACTION_BITS-1:0] sat_q [FRACTION_BITS+1];
    logic [FRACTION_BITS-1:0] hue_q [FRACTION_BITS+1];
    logic [CHANNEL_BITS-1:0]  value [FRACTION_BITS+1];
    rgbhsv_pkg::flags_t       flags [FRACTION_BITS+1];

    logic [FRACTION_BITS-1:0] hue_out;
    logic [FRACTION_BITS-1:0] sat_out;

    rgbhsv_front #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_red      (s_tdata[CHANNEL_BITS-1:0]),
        .in_green    (s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
        .in_blue     (s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
        .out_valid   (valid[0]),
        .out_ready   (ready[0]),
        .out_sat_rem (sat_rem[0]),
        .out_sat_div (sat_div[0]),
        .out_hue_rem (hue_rem[0]),
        .out_hue_div (hue_div[0]),
        .out_value   (value[0]),
        .out_flags   (flags[0])
    );

    assign sat_q[0] = '0;
    assign hue_q[0] = '0;

    for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
        rgbhsv_cell #(
            .CHANNEL_BITS (CHANNEL_BITS),
            .FRACTION_BITS(FRACTION_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .in_valid    (valid[i]),
            .in_ready    (ready[i]),
            .in_sat_rem  (sat_rem[i]),
            .in_sat_div  (sat_div[i]),
            .in_hue_rem  (hue_rem[i]),
            .in_hue_div  (hue_div[i]),
            .in_sat_q    (sat_q[i]),
            .in_hue_q    (hue_q[i]),
            .in_value    (value[i]),
            .in_flags    (flags[i]),
            .out_valid   (valid[i+1]),
            .out_ready   (ready[i+1]),
            .out_sat_rem (sat_rem[i+1]),
            .out_sat_div (sat_div[i+1]),
            .out_hue_rem (hue_rem[i+1]),
            .out_hue_div (hue_div[i+1]),
            .out_sat_q   (sat_q[i+1]),
            .out_hue_q   (hue_q[i+1]),
            .out_value   (value[i+1]),
            .out_flags   (flags[i+1])
        );
    end

    assign ready[FRACTION_BITS] = m_tready;
    assign m_tvalid             = valid[FRACTION_BITS];

    // grey, black and fully saturated pixels
    always_comb begin
        if (flags[FRACTION_BITS].hue_zero) begin
            hue_out = '0;
        end else begin
            hue_out = hue_q[FRACTION_BITS];
        end
        if (flags[FRACTION_BITS].sat_zero) begin
            sat_out = '0;
        end else if (flags[FRACTION_BITS].sat_full) begin
            sat_out = '1;
        end else begin
            sat_out = sat_q[FRACTION_BITS];
        end
    end

    assign m_tdata = OUT_W'(PACK_W'({value[FRACTION_BITS], sat_out, hue_out}));

endmodule
